>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define DBPM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("dbpm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DBPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dbpm assertion failed");

`endif

>>> hdl/dbpm_pkg.sv
`timescale 1ns / 1ps
package dbpm_pkg;

  localparam int unsigned OUT_W = 13;
  localparam int unsigned SYM_W = 8;

  localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h28;
  localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h29;

  localparam logic KIND_PAIR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_UNMATCHED_CLOSE = 3'd1,
    ST_UNCLOSED_OPEN   = 3'd2,
    ST_STACK_OVERFLOW  = 3'd3,
    ST_LENGTH_OVERFLOW = 3'd4
  } status_e;

  // Results caused by one accepted transaction, minus the popped position,
  // which arrives in the next cycle from the stack memory.
  typedef struct packed {
    logic             pair;
    logic             summ;
    logic [OUT_W-1:0] close_pos;
    status_e          pair_status;
    logic [OUT_W-1:0] sum_len;
    status_e          sum_status;
  } item_t;

endpackage

>>> hdl/dot_bracket_pair_matcher_core.sv
`timescale 1ns / 1ps
// Dot-bracket pair matcher.
// Input channel: one structure character per transaction on symbol_i, with
// last_symbol_i set on the final character. in_valid_i/in_stall_o handshake.
// Output channel: result transactions on out_valid_o/out_stall_i. A closing
// bracket with a pending opener gives a pair result (kind 0); the last
// character gives a summary (kind 1) with the length and status. A closing
// bracket flagged as last gives the pair first, then the summary.
// Pipeline: a result passes through stage one, which waits for the
// synchronous read of the bracket stack memory, and then the output register.
// Rate: one character per cycle while in_stall_o is low; an item with two
// results holds the output register until both have been taken.
// Characters that produce no result take no pipeline stage, but like any
// other they wait while in_stall_o is high.
// When the receiver stalls, the output register and one staged item hold,
// and in_stall_o rises once both are occupied.
// Reset clears the position, stack count and error code and empties the
// pipeline; the stack memory itself is not cleared and needs no sweep.
module dot_bracket_pair_matcher_core
  import dbpm_pkg::*;
#(
  parameter int unsigned MAX_LENGTH  = 4096,
  parameter int unsigned STACK_DEPTH = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       symbol_i,
  input  logic             last_symbol_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             kind_o,
  output logic [12:0]      open_position_o,
  output logic [12:0]      close_position_o,
  output logic [12:0]      structure_length_o,
  output logic [2:0]       status_o,
  output logic             last_result_o
);

  localparam int unsigned PW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic             accept;
  logic             busy;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [PW-1:0]    wdata, rdata;
  item_t            item;

  assign accept     = in_valid_i && !busy;
  assign in_stall_o = busy;

  dbpm_front #(
    .MAX_LENGTH (MAX_LENGTH),
    .STACK_DEPTH(STACK_DEPTH),
    .PW         (PW),
    .CW         (CW),
    .AW         (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .symbol_i     (symbol_i),
    .last_symbol_i(last_symbol_i),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .re_o         (re),
    .raddr_o      (raddr),
    .item_o       (item)
  );

  dbpm_stack_ram #(
    .DEPTH(STACK_DEPTH),
    .AW   (AW),
    .DW   (PW)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  dbpm_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .item_i            (item),
    .open_pos_i        (OUT_W'(rdata)),
    .busy_o            (busy),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .open_position_o   (open_position_o),
    .close_position_o  (close_position_o),
    .structure_length_o(structure_length_o),
    .status_o          (status_o),
    .last_result_o     (last_result_o)
  );

endmodule

>>> hdl/dbpm_stack_ram.sv
`timescale 1ns / 1ps
module dbpm_stack_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/dbpm_front.sv
`timescale 1ns / 1ps
module dbpm_front
  import dbpm_pkg::*;
#(
  parameter int unsigned MAX_LENGTH  = 4096,
  parameter int unsigned STACK_DEPTH = 2048,
  parameter int unsigned PW          = 13,
  parameter int unsigned CW          = 12,
  parameter int unsigned AW          = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             last_symbol_i,
  output logic             we_o,
  output logic [AW-1:0]    waddr_o,
  output logic [PW-1:0]    wdata_o,
  output logic             re_o,
  output logic [AW-1:0]    raddr_o,
  output item_t            item_o
);

  `include "assert_macros.svh"

  logic [PW-1:0] pos_q, pos_d, pos_inc;
  logic [CW-1:0] stk_q, stk_d, stk_dec;
  status_e       err_q, err_d, err_fin;
  logic          len_ok, stk_full;

  assign pos_inc  = pos_q + PW'(1);
  assign stk_dec  = stk_q - CW'(1);
  assign len_ok   = (pos_q < PW'(MAX_LENGTH));
  assign stk_full = (stk_q >= CW'(STACK_DEPTH));

  assign waddr_o = stk_q[AW-1:0];
  assign raddr_o = stk_dec[AW-1:0];
  assign wdata_o = pos_inc;

  always_comb begin
    pos_d   = pos_q;
    stk_d   = stk_q;
    err_d   = err_q;
    err_fin = err_q;
    we_o    = 1'b0;
    re_o    = 1'b0;
    item_o  = '0;
    item_o.close_pos   = OUT_W'(pos_inc);
    item_o.pair_status = err_q;
    if (accept_i) begin
      if (!len_ok) begin
        if (err_d == ST_OK) err_d = ST_LENGTH_OVERFLOW;
      end else begin
        pos_d = pos_inc;
        if (symbol_i == SYM_OPEN) begin
          if (stk_full) begin
            if (err_d == ST_OK) err_d = ST_STACK_OVERFLOW;
          end else begin
            we_o  = 1'b1;
            stk_d = stk_q + CW'(1);
          end
        end else if (symbol_i == SYM_CLOSE) begin
          if (stk_q == '0) begin
            if (err_d == ST_OK) err_d = ST_UNMATCHED_CLOSE;
          end else begin
            re_o        = 1'b1;
            stk_d       = stk_dec;
            item_o.pair = 1'b1;
          end
        end
      end
      if (last_symbol_i) begin
        err_fin = err_d;
        if (stk_d != '0 && err_fin == ST_OK) err_fin = ST_UNCLOSED_OPEN;
        item_o.summ       = 1'b1;
        item_o.sum_len    = OUT_W'(pos_d);
        item_o.sum_status = err_fin;
        // The structure is complete, so start the next one from scratch.
        pos_d = '0;
        stk_d = '0;
        err_d = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      stk_q <= '0;
      err_q <= ST_OK;
    end else begin
      pos_q <= pos_d;
      stk_q <= stk_d;
      err_q <= err_d;
    end
  end

  `DBPM_ASSERT(a_stack_bound, clk_i, rst_ni, stk_q <= CW'(STACK_DEPTH))
  `DBPM_ASSERT_NEXT(a_error_sticks, clk_i, rst_ni,
                    accept_i && !last_symbol_i && err_q != ST_OK, err_q == $past(err_q))

endmodule

>>> hdl/dbpm_out.sv
`timescale 1ns / 1ps
module dbpm_out
  import dbpm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  item_t            item_i,
  input  logic [OUT_W-1:0] open_pos_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             kind_o,
  output logic [OUT_W-1:0] open_position_o,
  output logic [OUT_W-1:0] close_position_o,
  output logic [OUT_W-1:0] structure_length_o,
  output logic [2:0]       status_o,
  output logic             last_result_o
);

  `include "assert_macros.svh"

  // Stage one waits for the stack read; the output stage presents results.
  logic             s1_valid_q, s1_valid_d;
  item_t            s1_q;
  logic             o_valid_q, o_valid_d;
  item_t            o_q;
  logic [OUT_W-1:0] o_open_q;
  logic             phase_pair_q, phase_pair_d;
  logic             out_acc, out_done, o_free, s1_adv;

  assign out_acc  = o_valid_q && !out_stall_i;
  assign out_done = out_acc && (!phase_pair_q || !o_q.summ);
  assign o_free   = !o_valid_q || out_done;
  assign s1_adv   = s1_valid_q && o_free;
  assign busy_o   = s1_valid_q && !o_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) s1_valid_d = 1'b0;
    if (accept_i && (item_i.pair || item_i.summ)) s1_valid_d = 1'b1;

    o_valid_d    = o_valid_q;
    phase_pair_d = phase_pair_q;
    if (out_done) o_valid_d = 1'b0;
    if (out_acc && phase_pair_q) phase_pair_d = 1'b0;
    if (s1_adv) begin
      o_valid_d    = 1'b1;
      phase_pair_d = s1_q.pair;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      o_valid_q    <= 1'b0;
      phase_pair_q <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      o_valid_q    <= o_valid_d;
      phase_pair_q <= phase_pair_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= item_i;
    end
    if (s1_adv) begin
      o_q      <= s1_q;
      o_open_q <= open_pos_i;
    end
  end

  always_comb begin
    out_valid_o = o_valid_q;
    if (phase_pair_q) begin
      kind_o             = KIND_PAIR;
      open_position_o    = o_open_q;
      close_position_o   = o_q.close_pos;
      structure_length_o = o_q.close_pos;
      status_o           = o_q.pair_status;
      last_result_o      = !o_q.summ;
    end else begin
      kind_o             = KIND_SUMMARY;
      open_position_o    = '0;
      close_position_o   = '0;
      structure_length_o = o_q.sum_len;
      status_o           = o_q.sum_status;
      last_result_o      = 1'b1;
    end
  end

  `DBPM_ASSERT(a_out_nonempty, clk_i, rst_ni, !o_valid_q || o_q.pair || o_q.summ)
  `DBPM_ASSERT(a_pair_phase, clk_i, rst_ni, !(o_valid_q && phase_pair_q) || o_q.pair)
  `DBPM_ASSERT_NEXT(a_pop_staged, clk_i, rst_ni, accept_i && item_i.pair, s1_valid_q && s1_q.pair)

endmodule

>>> sim/dbpm_match_checker.sv
`timescale 1ns / 1ps
module dbpm_match_checker
  import dbpm_pkg::*;
#(
  parameter int unsigned MAX_LENGTH  = 4096,
  parameter int unsigned STACK_DEPTH = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [7:0]       symbol_i,
  input  logic             last_symbol_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             kind_i,
  input  logic [12:0]      open_position_i,
  input  logic [12:0]      close_position_i,
  input  logic [12:0]      structure_length_i,
  input  logic [2:0]       status_i,
  input  logic             last_result_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int unsigned SLOT_W = $clog2(STACK_DEPTH);

  typedef struct packed {
    logic             kind;
    logic [OUT_W-1:0] open_pos;
    logic [OUT_W-1:0] close_pos;
    logic [OUT_W-1:0] length;
    status_e          status;
    logic             last;
  } match_result_t;

  match_result_t    expected_q[$];
  logic [OUT_W-1:0] open_stack [STACK_DEPTH];
  logic [OUT_W-1:0] stack_depth;
  logic [OUT_W-1:0] position;
  status_e          fault;
  int               mismatches = 0;

  assign fail_count_o = mismatches;

  // Only the first error of a structure is kept.
  function automatic void note_fault(input status_e code);
    if (fault == ST_OK) fault = code;
  endfunction

  function automatic void predict_results(input logic [7:0] sym, input logic fin);
    match_result_t r;
    if (position >= MAX_LENGTH) begin
      note_fault(ST_LENGTH_OVERFLOW);
    end else begin
      position = position + 1'b1;
      if (sym == SYM_OPEN) begin
        if (stack_depth >= STACK_DEPTH) begin
          note_fault(ST_STACK_OVERFLOW);
        end else begin
          open_stack[stack_depth[SLOT_W-1:0]] = position;
          stack_depth = stack_depth + 1'b1;
        end
      end else if (sym == SYM_CLOSE) begin
        if (stack_depth == 0) begin
          note_fault(ST_UNMATCHED_CLOSE);
        end else begin
          stack_depth = stack_depth - 1'b1;
          r.kind      = KIND_PAIR;
          r.open_pos  = open_stack[stack_depth[SLOT_W-1:0]];
          r.close_pos = position;
          r.length    = position;
          r.status    = fault;
          r.last      = !fin;
          expected_q.insert(expected_q.size(), r);
        end
      end
    end
    if (fin) begin
      if (stack_depth != 0) note_fault(ST_UNCLOSED_OPEN);
      r.kind      = KIND_SUMMARY;
      r.open_pos  = '0;
      r.close_pos = '0;
      r.length    = position;
      r.status    = fault;
      r.last      = 1'b1;
      expected_q.insert(expected_q.size(), r);
      stack_depth = '0;
      position    = '0;
      fault       = ST_OK;
    end
  endfunction

  function automatic void compare_field(input string label, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    match_result_t head;
    if (!rst_ni) begin
      expected_q.delete();
      stack_depth = '0;
      position    = '0;
      fault       = ST_OK;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: result transaction with none expected, expected none, actual kind %0d",
                   $time, kind_i);
        end else begin
          head = expected_q.pop_front();
          compare_field("kind", head.kind, kind_i);
          compare_field("open_position", head.open_pos, open_position_i);
          compare_field("close_position", head.close_pos, close_position_i);
          compare_field("structure_length", head.length, structure_length_i);
          compare_field("status", head.status, status_i);
          compare_field("last_result", head.last, last_result_i);
        end
      end
      if (in_valid_i && !in_stall_i) predict_results(symbol_i, last_symbol_i);
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> sim/tb_dot_bracket_pair_matcher_core.sv
`timescale 1ns / 1ps
module tb_dot_bracket_pair_matcher_core
  import dbpm_pkg::*;
();

  localparam int unsigned MAX_LENGTH  = 4096;
  localparam int unsigned STACK_DEPTH = 2048;
  localparam logic [7:0]  SYM_DOT     = 8'h2E;
  localparam int          RANDOM_ITEMS     = 1150;
  localparam int          LONG_HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT      = 3_000_000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  symbol      = '0;
  logic        last_symbol = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        kind;
  logic [12:0] open_position;
  logic [12:0] close_position;
  logic [12:0] structure_length;
  logic [2:0]  status;
  logic        last_result;
  int          fail_count;
  int          pending;
  int          cycles      = 0;
  int          items_sent  = 0;
  bit          calm        = 1'b0;
  bit          long_hold   = 1'b0;
  bit          hold_done   = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dot_bracket_pair_matcher_core #(
    .MAX_LENGTH (MAX_LENGTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .symbol_i          (symbol),
    .last_symbol_i     (last_symbol),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .kind_o            (kind),
    .open_position_o   (open_position),
    .close_position_o  (close_position),
    .structure_length_o(structure_length),
    .status_o          (status),
    .last_result_o     (last_result)
  );

  dbpm_match_checker #(
    .MAX_LENGTH (MAX_LENGTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_match_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .symbol_i          (symbol),
    .last_symbol_i     (last_symbol),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .kind_i            (kind),
    .open_position_i   (open_position),
    .close_position_i  (close_position),
    .structure_length_i(structure_length),
    .status_i          (status),
    .last_result_i     (last_result),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold on request, none at the end.
  initial begin : receiver
    int span;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        span = calm ? 1 : $urandom_range(1, 17);
        repeat (span) @(posedge clk_i);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end
  end

  // Offers one character and returns once taken, sometimes after an idle gap.
  task automatic send_symbol(input logic [7:0] sym, input logic fin);
    in_valid    <= 1'b1;
    symbol      <= sym;
    last_symbol <= fin;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_symbol(text[i], i == text.len() - 1);
  endtask

  function automatic logic [7:0] pick_unpaired();
    logic [7:0] sym;
    if ($urandom_range(0, 1) == 0) return SYM_DOT;
    do sym = 8'($urandom_range(0, 255)); while (sym == SYM_OPEN || sym == SYM_CLOSE);
    return sym;
  endfunction

  // Balanced structure of the given length with random unpaired characters.
  task automatic send_balanced(input int len);
    logic [7:0] sym;
    int         depth;
    int         left;
    int         pick;
    depth = 0;
    for (int i = 0; i < len; i++) begin
      left = len - i;
      if (depth == left) begin
        sym = SYM_CLOSE;
      end else begin
        pick = $urandom_range(0, 2);
        if (pick == 0 && depth < left - 1) sym = SYM_OPEN;
        else if (pick == 1 && depth > 0) sym = SYM_CLOSE;
        else sym = pick_unpaired();
      end
      if (sym == SYM_OPEN) depth++;
      else if (sym == SYM_CLOSE) depth--;
      send_symbol(sym, i == len - 1);
    end
  endtask

  // Structure likely to be unbalanced: stray closes, unclosed opens and arbitrary bytes.
  task automatic send_broken(input int len);
    logic [7:0] sym;
    int         pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) sym = SYM_OPEN;
      else if (pick < 7) sym = SYM_CLOSE;
      else sym = 8'($urandom_range(0, 255));
      send_symbol(sym, i == len - 1);
    end
  endtask

  // Waits until every expected result has been taken by the receiver.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text(".");
    send_text("()");
    send_text(")");
    send_text("(");
    send_text("((.)).");
    send_text(")(");
    send_text("())");
    send_symbol(8'h00, 1'b0);
    send_symbol(SYM_OPEN, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(SYM_CLOSE, 1'b0);
    send_symbol(8'h7F, 1'b1);
    drain();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > 400 && !hold_done) begin
        // The receiver holds off while the sender keeps offering transactions.
        hold_done = 1'b1;
        long_hold = 1'b1;
        send_balanced(90);
        drain();
      end
      if (items_sent > RANDOM_ITEMS - 150) calm = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0) send_broken(len);
      else send_balanced(len);
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
